FILE: rtl/lfo_wg_pkg.sv
// shared types, constants and helper functions of the lfo waveform generator
package lfo_wg_pkg;

    // default sizes handed to the top level parameters
    localparam int PHASE_BITS_DEF = 32;
    localparam int OUT_BITS_DEF   = 16;

    // quarter-wave sine resolution (power of two)
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_TGT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_SYNC   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIPOLAR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 3'd6;

    // wave shape codes
    localparam logic [2:0] SHAPE_SINE     = 3'd0;
    localparam logic [2:0] SHAPE_TRIANGLE = 3'd1;
    localparam logic [2:0] SHAPE_SAW      = 3'd2;
    localparam logic [2:0] SHAPE_SQUARE   = 3'd3;
    localparam logic [2:0] SHAPE_RANDOM   = 3'd4;
    localparam logic [2:0] SHAPE_SMOOTH   = 3'd5;

    // register reset values
    localparam logic [30:0] PHASE_INC_RST = 31'd1118481;
    localparam logic [15:0] DEPTH_FULL    = 16'd32768;
    localparam logic [31:0] LFSR_RST      = 32'd1;

    // depth smoothing, Q1.23 state
    localparam int          DEPTH_W    = 24;
    localparam logic [31:0] DEPTH_COEF = 32'd655;

    // random generator
    localparam logic [31:0] LFSR_MASK       = 32'h8020_0003;
    localparam int          LFSR_STEPS_CYC  = 4;

    // shared counter, covers four polynomial terms and the lfsr draw steps
    localparam int         CNT_W    = 2;
    localparam logic [1:0] CNT_LAST = 2'd3;

    // Q30 work values
    localparam int                POLY_W  = 33;
    localparam int                ARG_W   = 30;
    localparam logic signed [32:0] POLY_C4 = 33'sd172272;

    function automatic logic signed [POLY_W-1:0] poly_coef(input logic [CNT_W-1:0] idx);
        logic signed [POLY_W-1:0] c;
        case (idx)
            2'd0:    c = -33'sd5026995;
            2'd1:    c = 33'sd85569306;
            2'd2:    c = -33'sd693598668;
            default: c = 33'sd1686629713;
        endcase
        return c;
    endfunction

    // one galois shift
    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        logic [31:0] s;
        s = {1'b0, v[31:1]};
        if (v[0]) begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DEPTH_MUL,
        ST_DEPTH_WB,
        ST_SETUP,
        ST_X2_MUL,
        ST_X2_WB,
        ST_POLY_MUL,
        ST_POLY_WB,
        ST_SIN_MUL,
        ST_SIN_WB,
        ST_SINE_FIN,
        ST_SQ_MUL,
        ST_SQ_WB,
        ST_MIX_MUL,
        ST_MIX_WB,
        ST_OUT_MUL,
        ST_OUT_WB,
        ST_DRAW,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DEPTH,
        MUL_X2,
        MUL_POLY,
        MUL_SIN,
        MUL_SQ,
        MUL_MIX,
        MUL_OUT
    } t_mul_sel;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_DEPTH,
        WB_X2,
        WB_POLY,
        WB_SIN,
        WB_SINE_FIN,
        WB_SQ,
        WB_MIX,
        WB_OUT
    } t_wb_sel;

    typedef struct packed {
        logic             trig;
        logic             setup;
        t_mul_sel         mul_sel;
        t_wb_sel          wb_sel;
        logic [CNT_W-1:0] cnt;
        logic             draw_step;
        logic             draw_last;
        logic             load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] wave_shape;
        logic       wrap;
        logic       out_free;
    } t_dp_status;

endpackage

FILE: rtl/lfo_wg_ctrl.sv
// sequencer that steps one sample through the shared multiplier datapath
module lfo_wg_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  lfo_wg_pkg::t_dp_status  i_status,
    output lfo_wg_pkg::t_dp_cmd     o_cmd
);

    lfo_wg_pkg::t_state r_state, n_state;
    logic [lfo_wg_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic shape_poly, shape_draw;

    assign shape_poly = i_status.wave_shape inside {lfo_wg_pkg::SHAPE_SINE,
                                                    lfo_wg_pkg::SHAPE_SMOOTH};
    assign shape_draw = i_status.wave_shape inside {lfo_wg_pkg::SHAPE_RANDOM,
                                                    lfo_wg_pkg::SHAPE_SMOOTH};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfo_wg_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // loop counter, back at zero after each four-pass loop
    always_comb begin
        n_cnt = r_cnt;
        if (r_state == lfo_wg_pkg::ST_POLY_WB || r_state == lfo_wg_pkg::ST_DRAW) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lfo_wg_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lfo_wg_pkg::ST_DEPTH_MUL;
                end
            end
            lfo_wg_pkg::ST_DEPTH_MUL: n_state = lfo_wg_pkg::ST_DEPTH_WB;
            lfo_wg_pkg::ST_DEPTH_WB:  n_state = lfo_wg_pkg::ST_SETUP;
            lfo_wg_pkg::ST_SETUP: begin
                n_state = shape_poly ? lfo_wg_pkg::ST_X2_MUL : lfo_wg_pkg::ST_OUT_MUL;
            end
            lfo_wg_pkg::ST_X2_MUL:    n_state = lfo_wg_pkg::ST_X2_WB;
            lfo_wg_pkg::ST_X2_WB:     n_state = lfo_wg_pkg::ST_POLY_MUL;
            lfo_wg_pkg::ST_POLY_MUL:  n_state = lfo_wg_pkg::ST_POLY_WB;
            lfo_wg_pkg::ST_POLY_WB: begin
                n_state = (r_cnt == lfo_wg_pkg::CNT_LAST) ? lfo_wg_pkg::ST_SIN_MUL
                                                          : lfo_wg_pkg::ST_POLY_MUL;
            end
            lfo_wg_pkg::ST_SIN_MUL:   n_state = lfo_wg_pkg::ST_SIN_WB;
            lfo_wg_pkg::ST_SIN_WB: begin
                n_state = (i_status.wave_shape == lfo_wg_pkg::SHAPE_SINE)
                        ? lfo_wg_pkg::ST_SINE_FIN : lfo_wg_pkg::ST_SQ_MUL;
            end
            lfo_wg_pkg::ST_SINE_FIN:  n_state = lfo_wg_pkg::ST_OUT_MUL;
            lfo_wg_pkg::ST_SQ_MUL:    n_state = lfo_wg_pkg::ST_SQ_WB;
            lfo_wg_pkg::ST_SQ_WB:     n_state = lfo_wg_pkg::ST_MIX_MUL;
            lfo_wg_pkg::ST_MIX_MUL:   n_state = lfo_wg_pkg::ST_MIX_WB;
            lfo_wg_pkg::ST_MIX_WB:    n_state = lfo_wg_pkg::ST_OUT_MUL;
            lfo_wg_pkg::ST_OUT_MUL:   n_state = lfo_wg_pkg::ST_OUT_WB;
            lfo_wg_pkg::ST_OUT_WB: begin
                n_state = (i_status.wrap && shape_draw) ? lfo_wg_pkg::ST_DRAW
                                                        : lfo_wg_pkg::ST_DONE;
            end
            lfo_wg_pkg::ST_DRAW: begin
                if (r_cnt == lfo_wg_pkg::CNT_LAST) begin
                    n_state = lfo_wg_pkg::ST_DONE;
                end
            end
            lfo_wg_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = lfo_wg_pkg::ST_IDLE;
                end
            end
            default: n_state = lfo_wg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.mul_sel   = lfo_wg_pkg::MUL_NONE;
        o_cmd.wb_sel    = lfo_wg_pkg::WB_NONE;
        o_cmd.cnt       = r_cnt;
        case (r_state)
            lfo_wg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.trig = i_in_valid;
            end
            lfo_wg_pkg::ST_DEPTH_MUL: o_cmd.mul_sel = lfo_wg_pkg::MUL_DEPTH;
            lfo_wg_pkg::ST_DEPTH_WB:  o_cmd.wb_sel  = lfo_wg_pkg::WB_DEPTH;
            lfo_wg_pkg::ST_SETUP:     o_cmd.setup   = 1'b1;
            lfo_wg_pkg::ST_X2_MUL:    o_cmd.mul_sel = lfo_wg_pkg::MUL_X2;
            lfo_wg_pkg::ST_X2_WB:     o_cmd.wb_sel  = lfo_wg_pkg::WB_X2;
            lfo_wg_pkg::ST_POLY_MUL:  o_cmd.mul_sel = lfo_wg_pkg::MUL_POLY;
            lfo_wg_pkg::ST_POLY_WB:   o_cmd.wb_sel  = lfo_wg_pkg::WB_POLY;
            lfo_wg_pkg::ST_SIN_MUL:   o_cmd.mul_sel = lfo_wg_pkg::MUL_SIN;
            lfo_wg_pkg::ST_SIN_WB:    o_cmd.wb_sel  = lfo_wg_pkg::WB_SIN;
            lfo_wg_pkg::ST_SINE_FIN:  o_cmd.wb_sel  = lfo_wg_pkg::WB_SINE_FIN;
            lfo_wg_pkg::ST_SQ_MUL:    o_cmd.mul_sel = lfo_wg_pkg::MUL_SQ;
            lfo_wg_pkg::ST_SQ_WB:     o_cmd.wb_sel  = lfo_wg_pkg::WB_SQ;
            lfo_wg_pkg::ST_MIX_MUL:   o_cmd.mul_sel = lfo_wg_pkg::MUL_MIX;
            lfo_wg_pkg::ST_MIX_WB:    o_cmd.wb_sel  = lfo_wg_pkg::WB_MIX;
            lfo_wg_pkg::ST_OUT_MUL:   o_cmd.mul_sel = lfo_wg_pkg::MUL_OUT;
            lfo_wg_pkg::ST_OUT_WB:    o_cmd.wb_sel  = lfo_wg_pkg::WB_OUT;
            lfo_wg_pkg::ST_DRAW: begin
                o_cmd.draw_step = 1'b1;
                o_cmd.draw_last = (r_cnt == lfo_wg_pkg::CNT_LAST);
            end
            lfo_wg_pkg::ST_DONE:      o_cmd.load_out = i_status.out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/lfo_wg_dp.sv
// datapath: config and oscillator state, shared multiplier, wave shaping, output register
module lfo_wg_dp #(
    parameter int PHASE_BITS = lfo_wg_pkg::PHASE_BITS_DEF,
    parameter int OUT_BITS   = lfo_wg_pkg::OUT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lfo_wg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lfo_wg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                i_retrigger,
    input  lfo_wg_pkg::t_dp_cmd                 i_cmd,
    output lfo_wg_pkg::t_dp_status              o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [OUT_BITS-1:0]          o_lfo_value,
    output logic                                o_cycle_start
);

    localparam int SH = 39 - OUT_BITS;
    localparam int YW = OUT_BITS + 3;
    localparam int YE = YW + 1;
    localparam int IB = lfo_wg_pkg::SINE_IDX_BITS;

    localparam logic signed [41:0]   Y_RND = 42'sd1 <<< (SH - 1);
    localparam logic signed [YE-1:0] Y_TOP = {{(YE-OUT_BITS){1'b0}}, 1'b1,
                                              {(OUT_BITS-1){1'b0}}};
    localparam logic signed [YE-1:0] Y_MAX = Y_TOP - 1'b1;
    localparam logic signed [YE-1:0] Y_MIN = -Y_TOP;

    // configuration
    logic [30:0] r_phase_inc;
    logic [15:0] r_depth_tgt;
    logic [15:0] r_start_phase;
    logic [2:0]  r_wave_shape;
    logic        r_trig_sync;
    logic        r_bipolar;

    // oscillator state
    logic [PHASE_BITS-1:0]              r_phase;
    logic [lfo_wg_pkg::DEPTH_W-1:0]     r_sdepth;
    logic signed [15:0]                 r_held;
    logic signed [15:0]                 r_next;
    logic [31:0]                        r_lfsr;

    // work registers
    logic [lfo_wg_pkg::ARG_W-1:0]       r_arg;
    logic signed [lfo_wg_pkg::POLY_W-1:0] r_poly;
    logic signed [lfo_wg_pkg::POLY_W-1:0] r_x2;
    logic signed [17:0]                 r_wave;
    logic [1:0]                         r_quad;
    logic [63:0]                        r_prod_mag;
    logic                               r_prod_neg;
    logic signed [YW-1:0]               r_y;
    logic                               r_wrap;

    // output register
    logic                               r_out_valid;
    logic signed [OUT_BITS-1:0]         r_out_value;
    logic                               r_out_cycle;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] a;
        a = v[32] ? 33'(-v) : 33'(v);
        return a[31:0];
    endfunction

    // depth target and smoothing step direction
    logic [15:0]                    depth_clamp;
    logic [lfo_wg_pkg::DEPTH_W-1:0] tgt, dep_diff, dep_step;
    logic                           tgt_ge;
    logic [34:0]                    dstep_sum;

    assign depth_clamp = (r_depth_tgt > lfo_wg_pkg::DEPTH_FULL) ? lfo_wg_pkg::DEPTH_FULL
                                                                : r_depth_tgt;
    assign tgt       = {depth_clamp, 8'b0};
    assign tgt_ge    = (tgt >= r_sdepth);
    assign dep_diff  = tgt_ge ? (tgt - r_sdepth) : (r_sdepth - tgt);
    assign dstep_sum = r_prod_mag[34:0] + 35'd32768;
    assign dep_step  = {5'b0, dstep_sum[34:16]};

    // phase views
    logic [PHASE_BITS+31:0] ph_wide;
    logic [31:0]            ph32;
    logic [PHASE_BITS+30:0] inc_wide;
    logic [PHASE_BITS-2:0]  inc;
    logic [PHASE_BITS:0]    phase_sum;
    logic [PHASE_BITS+15:0] start_wide;
    logic [PHASE_BITS-1:0]  start_ph;

    assign ph_wide    = {r_phase, 32'b0};
    assign ph32       = ph_wide[PHASE_BITS+31 -: 32];
    assign inc_wide   = {r_phase_inc, {PHASE_BITS{1'b0}}};
    assign inc        = inc_wide[PHASE_BITS+30:32];
    assign phase_sum  = {1'b0, r_phase} + {2'b0, inc};
    assign start_wide = {r_start_phase, {PHASE_BITS{1'b0}}};
    assign start_ph   = start_wide[PHASE_BITS+15:16];

    // table argument of the quarter-wave sine, mirrored in odd quadrants
    logic [IB-1:0]                 sine_idx;
    logic [lfo_wg_pkg::ARG_W-1:0]  sine_arg;

    assign sine_idx = ph32[30] ? ~ph32[29 -: IB] : ph32[29 -: IB];
    assign sine_arg = {sine_idx, 1'b1, {(29-IB){1'b0}}};

    // shapes that need no multiplier
    logic [16:0]        tri_t;
    logic signed [18:0] tri_s, tri_v;
    logic signed [17:0] tri_w, simple_wave;

    assign tri_t = ph32[31:15];
    assign tri_s = $signed({2'b0, tri_t});

    always_comb begin
        if (tri_t < 17'd32768) begin
            tri_v = tri_s;
        end else if (tri_t < 17'd98304) begin
            tri_v = 19'sd65536 - tri_s;
        end else begin
            tri_v = tri_s - 19'sd131072;
        end
        tri_w = (tri_v > 19'sd32767) ? 18'sd32767 : tri_v[17:0];
    end

    always_comb begin
        case (r_wave_shape)
            lfo_wg_pkg::SHAPE_TRIANGLE: simple_wave = tri_w;
            lfo_wg_pkg::SHAPE_SAW: begin
                simple_wave = $signed({{2{~ph32[31]}}, ~ph32[31], ph32[30:16]});
            end
            lfo_wg_pkg::SHAPE_SQUARE:   simple_wave = ph32[31] ? -18'sd32768 : 18'sd32767;
            lfo_wg_pkg::SHAPE_RANDOM:   simple_wave = {{2{r_held[15]}}, r_held};
            default:                    simple_wave = 18'sd0;
        endcase
    end

    // shared multiplier operand select, sign-magnitude
    logic [31:0]        mul_a, mul_b;
    logic               mul_neg;
    logic signed [16:0] rnd_diff;
    logic [63:0]        prod_c;

    assign rnd_diff = {r_next[15], r_next} - {r_held[15], r_held};

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (i_cmd.mul_sel)
            lfo_wg_pkg::MUL_DEPTH: begin
                mul_a = {8'b0, dep_diff};
                mul_b = lfo_wg_pkg::DEPTH_COEF;
            end
            lfo_wg_pkg::MUL_X2: begin
                mul_a = {2'b0, r_arg};
                mul_b = {2'b0, r_arg};
            end
            lfo_wg_pkg::MUL_POLY: begin
                mul_a   = mag33(r_poly);
                mul_b   = mag33(r_x2);
                mul_neg = r_poly[32] ^ r_x2[32];
            end
            lfo_wg_pkg::MUL_SIN: begin
                mul_a   = mag33(r_poly);
                mul_b   = {2'b0, r_arg};
                mul_neg = r_poly[32];
            end
            lfo_wg_pkg::MUL_SQ: begin
                mul_a = mag33(r_poly);
                mul_b = mag33(r_poly);
            end
            lfo_wg_pkg::MUL_MIX: begin
                mul_a   = mag33({{16{rnd_diff[16]}}, rnd_diff});
                mul_b   = mag33(r_x2);
                mul_neg = rnd_diff[16] ^ r_x2[32];
            end
            lfo_wg_pkg::MUL_OUT: begin
                mul_a   = mag33({{15{r_wave[17]}}, r_wave});
                mul_b   = {8'b0, r_sdepth};
                mul_neg = r_wave[17];
            end
            default: ;
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // Q30 rounding of the registered product, on the magnitude
    logic [63:0]                          q30_sum;
    logic signed [lfo_wg_pkg::POLY_W-1:0] q30;

    assign q30_sum = r_prod_mag + 64'h2000_0000;
    assign q30 = r_prod_neg ? -$signed({1'b0, q30_sum[61:30]})
                            : $signed({1'b0, q30_sum[61:30]});

    // sine table entry from the polynomial, clamped, then quadrant sign
    logic [32:0]        s_clip;
    logic [33:0]        s_rnd;
    logic [15:0]        s_mag;
    logic signed [17:0] sine_val;

    assign s_clip   = r_poly[32] ? 33'd0 : r_poly;
    assign s_rnd    = {1'b0, s_clip} + 34'd16384;
    assign s_mag    = (s_rnd[33:15] > 19'd32767) ? 16'd32767 : s_rnd[30:15];
    assign sine_val = r_quad[1] ? -$signed({2'b0, s_mag}) : $signed({2'b0, s_mag});

    // smooth random blend
    logic signed [17:0] mix_val;

    assign mix_val = {{2{r_held[15]}}, r_held} + q30[17:0];

    // output scaling and rounding
    logic signed [41:0] out_ps, out_rs;

    assign out_ps = r_prod_neg ? -$signed({1'b0, r_prod_mag[40:0]})
                               : $signed({1'b0, r_prod_mag[40:0]});
    assign out_rs = out_ps + Y_RND;

    // unipolar map and saturation at the output register
    logic signed [YE-1:0] y_ext, y_uni, y_uni_c, y_sel, y_sat;

    assign y_ext   = {r_y[YW-1], r_y};
    assign y_uni   = y_ext + Y_TOP;
    assign y_uni_c = y_uni[YE-1] ? '0 : y_uni;
    assign y_sel   = r_bipolar ? y_ext : $signed({1'b0, y_uni_c[YE-1:1]});
    assign y_sat   = (y_sel > Y_MAX) ? Y_MAX : ((y_sel < Y_MIN) ? Y_MIN : y_sel);

    // four lfsr shifts per draw cycle
    logic [31:0] lfsr_nx;

    always_comb begin
        lfsr_nx = r_lfsr;
        for (int k = 0; k < lfo_wg_pkg::LFSR_STEPS_CYC; k++) begin
            lfsr_nx = lfo_wg_pkg::lfsr_step(lfsr_nx);
        end
    end

    // configuration and oscillator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc   <= lfo_wg_pkg::PHASE_INC_RST;
            r_depth_tgt   <= lfo_wg_pkg::DEPTH_FULL;
            r_start_phase <= '0;
            r_wave_shape  <= lfo_wg_pkg::SHAPE_SINE;
            r_trig_sync   <= 1'b0;
            r_bipolar     <= 1'b1;
            r_phase       <= '0;
            r_sdepth      <= {lfo_wg_pkg::DEPTH_FULL, 8'b0};
            r_held        <= '0;
            r_next        <= '0;
            r_lfsr        <= lfo_wg_pkg::LFSR_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lfo_wg_pkg::REG_PHASE_INC:   r_phase_inc   <= i_cfg_data[30:0];
                    lfo_wg_pkg::REG_DEPTH_TGT:   r_depth_tgt   <= i_cfg_data[15:0];
                    lfo_wg_pkg::REG_START_PHASE: r_start_phase <= i_cfg_data[15:0];
                    lfo_wg_pkg::REG_WAVE_SHAPE:  r_wave_shape  <= i_cfg_data[2:0];
                    lfo_wg_pkg::REG_TRIG_SYNC:   r_trig_sync   <= i_cfg_data[0];
                    lfo_wg_pkg::REG_BIPOLAR:     r_bipolar     <= i_cfg_data[0];
                    lfo_wg_pkg::REG_RANDOM_SEED: begin
                        r_lfsr <= (i_cfg_data == '0) ? lfo_wg_pkg::LFSR_RST : i_cfg_data;
                    end
                    default: ;
                endcase
            end

            if (i_cmd.trig && i_retrigger && r_trig_sync) begin
                r_phase  <= start_ph;
                r_held   <= '0;
                r_next   <= '0;
                r_sdepth <= tgt;
            end

            if (i_cmd.wb_sel == lfo_wg_pkg::WB_DEPTH) begin
                r_sdepth <= tgt_ge ? (r_sdepth + dep_step) : (r_sdepth - dep_step);
            end

            if (i_cmd.wb_sel == lfo_wg_pkg::WB_OUT) begin
                r_phase <= phase_sum[PHASE_BITS-1:0];
            end

            if (i_cmd.draw_step) begin
                r_lfsr <= lfsr_nx;
                if (i_cmd.draw_last) begin
                    if (r_wave_shape == lfo_wg_pkg::SHAPE_SMOOTH) begin
                        r_held <= r_next;
                        r_next <= $signed(lfsr_nx[15:0]);
                    end else begin
                        r_held <= $signed(lfsr_nx[15:0]);
                    end
                end
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // work registers and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sel != lfo_wg_pkg::MUL_NONE) begin
            r_prod_mag <= prod_c;
            r_prod_neg <= mul_neg;
        end

        if (i_cmd.setup) begin
            r_arg  <= (r_wave_shape == lfo_wg_pkg::SHAPE_SMOOTH) ? ph32[31:2] : sine_arg;
            r_quad <= ph32[31:30];
            r_poly <= lfo_wg_pkg::POLY_C4;
            r_wave <= simple_wave;
        end

        case (i_cmd.wb_sel)
            lfo_wg_pkg::WB_X2:       r_x2   <= q30;
            lfo_wg_pkg::WB_POLY:     r_poly <= lfo_wg_pkg::poly_coef(i_cmd.cnt) + q30;
            lfo_wg_pkg::WB_SIN:      r_poly <= q30;
            lfo_wg_pkg::WB_SINE_FIN: r_wave <= sine_val;
            lfo_wg_pkg::WB_SQ:       r_x2   <= q30;
            lfo_wg_pkg::WB_MIX:      r_wave <= mix_val;
            lfo_wg_pkg::WB_OUT: begin
                r_y    <= $signed(out_rs[41:SH]);
                r_wrap <= phase_sum[PHASE_BITS];
            end
            default: ;
        endcase

        if (i_cmd.load_out) begin
            r_out_value <= y_sat[OUT_BITS-1:0];
            r_out_cycle <= r_wrap;
        end
    end

    assign o_status.wave_shape = r_wave_shape;
    assign o_status.wrap       = phase_sum[PHASE_BITS];
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_lfo_value   = r_out_value;
    assign o_cycle_start = r_out_cycle;

endmodule

FILE: rtl/lfo_waveform_generator_unit.sv
// top level of the low-frequency oscillator: sequencer plus shared-multiplier datapath
//
// One input item is one sample tick. Its retrigger bit restarts the oscillator (phase to
// start_phase, both random values to zero, depth smoothing to the target) when trigger_sync
// is set. The tick then moves the smoothed depth one step toward depth_target, forms the
// wave value of the current phase, scales it by the smoothed depth, optionally maps it to
// unipolar, and advances the phase by phase_increment; one result item carries the value
// and a flag that the phase wrapped. Every multiplication of the tick goes through one
// registered 32x32 multiplier, each product in a multiply and a writeback state, so the
// cost per item depends on the shape: triangle, saw, square and random hold need only
// the depth and output products, sine adds the odd polynomial over the quarter wave,
// smooth random the same polynomial plus the squared blend, and a wrap that draws a
// random value adds the draw states (16 lfsr shifts, four per cycle). A finished result
// sits in an output register, so a new tick is taken while it waits; only the next
// result waits for that register to free. Configuration writes take effect at once and
// belong between ticks; a seed write also loads the lfsr (zero is taken as one).
module lfo_waveform_generator_unit #(
    parameter int PHASE_BITS = lfo_wg_pkg::PHASE_BITS_DEF,
    parameter int OUT_BITS   = lfo_wg_pkg::OUT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [lfo_wg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lfo_wg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // sample tick items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_retrigger,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [OUT_BITS-1:0]          o_lfo_value,
    output logic                                o_cycle_start
);

    lfo_wg_pkg::t_dp_cmd    cmd;
    lfo_wg_pkg::t_dp_status status;

    // sequencer: walks each tick through depth step, wave build, scaling and draw
    lfo_wg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: registers, the shared multiplier and the output register
    lfo_wg_dp #(
        .PHASE_BITS (PHASE_BITS),
        .OUT_BITS   (OUT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_retrigger   (i_retrigger),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_lfo_value   (o_lfo_value),
        .o_cycle_start (o_cycle_start)
    );

endmodule

FILE: dv/lfo_waveform_generator_unit_tb.sv
// self-checking testbench of the lfo waveform generator with a bit-exact predictor
module lfo_waveform_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // spare shape codes and the register index that the block has no register for
    localparam logic [2:0]                      SHAPE_SPARE_LO = 3'd6;
    localparam logic [2:0]                      SHAPE_SPARE_HI = 3'd7;
    localparam logic [lfo_wg_pkg::CFG_IDX_W-1:0] REG_NONE      = 3'd7;

    localparam int RANDOM_TICKS  = 1100;
    localparam int SETTLE_CYCLES = 40;    // worst tick is smooth random plus a draw
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int DRAIN_LIMIT   = 5000;
    localparam int MAX_PRINT     = 60;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_BURSTY
    } t_rx_mode;

    typedef struct packed {
        logic signed [lfo_wg_pkg::OUT_BITS_DEF-1:0] value;
        logic                                       wrap;
    } t_lfo_sample;

    // predicts every sample of the oscillator and holds the ones still owed by the block
    class lfo_sample_checker;
        // register copies
        logic [30:0] phase_inc;
        logic [15:0] depth_tgt;
        logic [15:0] start_ph;
        logic [2:0]  shape;
        logic        trig_sync;
        logic        bipolar;
        // oscillator state
        logic [31:0] phase_acc;
        logic [23:0] depth_smooth;
        int          held_rnd;
        int          next_rnd;
        logic [31:0] lfsr;
        int          sine_rom [lfo_wg_pkg::SINE_TABLE_DEPTH];
        t_lfo_sample expected_samples [$];
        int          mismatches;

        function new();
            longint a;
            longint s;
            longint r;
            phase_inc    = lfo_wg_pkg::PHASE_INC_RST;
            depth_tgt    = lfo_wg_pkg::DEPTH_FULL;
            start_ph     = '0;
            shape        = lfo_wg_pkg::SHAPE_SINE;
            trig_sync    = 1'b0;
            bipolar      = 1'b1;
            phase_acc    = '0;
            depth_smooth = 24'(lfo_wg_pkg::DEPTH_FULL) << 8;
            held_rnd     = 0;
            next_rnd     = 0;
            lfsr         = lfo_wg_pkg::LFSR_RST;
            mismatches   = 0;
            // quarter-wave table, sampled at the middle of each step
            for (int k = 0; k < lfo_wg_pkg::SINE_TABLE_DEPTH; k++) begin
                a = (longint'(2 * k + 1) << 29) / lfo_wg_pkg::SINE_TABLE_DEPTH;
                s = sin_q30(a);
                if (s < 0) s = 0;
                r = (s + (longint'(1) << 14)) >>> 15;
                sine_rom[k] = (r > 32767) ? 32767 : int'(r);
            end
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINT) $display("mismatch: %s", what);
            mismatches++;
        endtask

        // sign-magnitude q30 product, rounded half up on the magnitude
        function longint mul_q30(longint a, longint b);
            bit              neg;
            longint unsigned ma;
            longint unsigned mb;
            longint unsigned m;
            neg = (a < 0) != (b < 0);
            ma  = (a < 0) ? -a : a;
            mb  = (b < 0) ? -b : b;
            m   = (ma * mb + (64'd1 << 29)) >> 30;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        // sin(pi/2 * a), a in q30 over [0,1]
        function longint sin_q30(longint a);
            longint x2;
            longint p;
            x2 = mul_q30(a, a);
            p  = 172272;
            p  = -64'sd5026995 + mul_q30(p, x2);
            p  = 64'sd85569306 + mul_q30(p, x2);
            p  = -64'sd693598668 + mul_q30(p, x2);
            p  = 64'sd1686629713 + mul_q30(p, x2);
            return mul_q30(p, a);
        endfunction

        function int sine_wave(logic [31:0] ph);
            int idx;
            idx = int'((longint'(ph[29:14]) * lfo_wg_pkg::SINE_TABLE_DEPTH) >> 16);
            if (ph[30]) idx = lfo_wg_pkg::SINE_TABLE_DEPTH - 1 - idx;
            return ph[31] ? -sine_rom[idx] : sine_rom[idx];
        endfunction

        function int triangle_wave(logic [31:0] ph);
            int t;
            int v;
            t = int'(ph >> 15);
            if (t < 32768) v = t;
            else if (t < 98304) v = 65536 - t;
            else v = t - 131072;
            return (v > 32767) ? 32767 : v;
        endfunction

        // cosine blend from held toward next over one cycle
        function int smooth_wave(logic [31:0] ph);
            longint s;
            longint w;
            s = sin_q30(longint'(ph >> 2));
            w = mul_q30(s, s);
            return held_rnd + int'(mul_q30(longint'(next_rnd - held_rnd), w));
        endfunction

        function int draw_random_value();
            if (lfsr == '0) lfsr = 32'd1;
            repeat (16) begin
                lfsr = lfsr[0] ? ({1'b0, lfsr[31:1]} ^ lfo_wg_pkg::LFSR_MASK)
                               : {1'b0, lfsr[31:1]};
            end
            return int'($signed(lfsr[15:0]));
        endfunction

        function int unsigned depth_clamped();
            return (depth_tgt > lfo_wg_pkg::DEPTH_FULL) ? int'(lfo_wg_pkg::DEPTH_FULL)
                                                        : int'(depth_tgt);
        endfunction

        function void apply_reg(logic [lfo_wg_pkg::CFG_IDX_W-1:0] idx,
                                logic [lfo_wg_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lfo_wg_pkg::REG_PHASE_INC:   phase_inc = data[30:0];
                lfo_wg_pkg::REG_DEPTH_TGT:   depth_tgt = data[15:0];
                lfo_wg_pkg::REG_START_PHASE: start_ph  = data[15:0];
                lfo_wg_pkg::REG_WAVE_SHAPE:  shape     = data[2:0];
                lfo_wg_pkg::REG_TRIG_SYNC:   trig_sync = data[0];
                lfo_wg_pkg::REG_BIPOLAR:     bipolar   = data[0];
                lfo_wg_pkg::REG_RANDOM_SEED: begin
                    lfsr = (data == '0) ? 32'd1 : data;
                end
                default: ;
            endcase
        endfunction

        // one sample tick: predict its sample and queue it
        function void note_tick(logic retrig);
            int unsigned tgt;
            int unsigned mag;
            int unsigned stepv;
            int          wave;
            longint      prod;
            longint      y;
            longint      b;
            logic [32:0] sum;
            t_lfo_sample smp;
            if (retrig && trig_sync) begin
                phase_acc    = {start_ph, 16'h0000};
                held_rnd     = 0;
                next_rnd     = 0;
                depth_smooth = 24'(depth_clamped() << 8);
            end
            tgt = depth_clamped() << 8;
            if (tgt >= depth_smooth) begin
                mag          = tgt - depth_smooth;
                stepv        = int'((longint'(mag) * lfo_wg_pkg::DEPTH_COEF + 32768) >> 16);
                depth_smooth = 24'(depth_smooth + stepv);
            end else begin
                mag          = depth_smooth - tgt;
                stepv        = int'((longint'(mag) * lfo_wg_pkg::DEPTH_COEF + 32768) >> 16);
                depth_smooth = 24'(depth_smooth - stepv);
            end
            case (shape)
                lfo_wg_pkg::SHAPE_SINE:     wave = sine_wave(phase_acc);
                lfo_wg_pkg::SHAPE_TRIANGLE: wave = triangle_wave(phase_acc);
                lfo_wg_pkg::SHAPE_SAW:      wave = int'(phase_acc[31:16]) - 32768;
                lfo_wg_pkg::SHAPE_SQUARE:   wave = phase_acc[31] ? -32768 : 32767;
                lfo_wg_pkg::SHAPE_RANDOM:   wave = held_rnd;
                lfo_wg_pkg::SHAPE_SMOOTH:   wave = smooth_wave(phase_acc);
                default:                    wave = 0;
            endcase
            // q1.15 times q1.23, rounded back to q1.15
            prod = longint'(wave) * longint'(depth_smooth);
            y = ((prod + (longint'(1) << 40) + (longint'(1) << 22)) >>> 23)
                - (longint'(1) << 17);
            if (!bipolar) begin
                b = y + 32768;
                if (b < 0) b = 0;
                y = b >>> 1;
            end
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            sum       = {1'b0, phase_acc} + {2'b00, phase_inc};
            phase_acc = sum[31:0];
            if (sum[32]) begin
                if (shape == lfo_wg_pkg::SHAPE_RANDOM) begin
                    held_rnd = draw_random_value();
                end else if (shape == lfo_wg_pkg::SHAPE_SMOOTH) begin
                    held_rnd = next_rnd;
                    next_rnd = draw_random_value();
                end
            end
            smp.value = y[15:0];
            smp.wrap  = sum[32];
            expected_samples.push_back(smp);
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        task check_sample(logic signed [lfo_wg_pkg::OUT_BITS_DEF-1:0] value, logic wrap);
            t_lfo_sample exp_smp;
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("sample %0d/%0b with nothing owed", value, wrap));
                return;
            end
            exp_smp = expected_samples.pop_front();
            if (value !== exp_smp.value)
                report_mismatch($sformatf("lfo_value %0d, wanted %0d", value, exp_smp.value));
            if (wrap !== exp_smp.wrap)
                report_mismatch($sformatf("cycle_start %b, wanted %b", wrap, exp_smp.wrap));
        endtask
    endclass

    logic                                       i_clk;
    logic                                       i_rst_n;
    logic                                       i_cfg_we;
    logic [lfo_wg_pkg::CFG_IDX_W-1:0]           i_cfg_index;
    logic [lfo_wg_pkg::CFG_DATA_W-1:0]          i_cfg_data;
    logic                                       i_in_valid;
    logic                                       o_in_ready;
    logic                                       i_retrigger;
    logic                                       o_out_valid;
    logic                                       i_out_ready;
    logic signed [lfo_wg_pkg::OUT_BITS_DEF-1:0] o_lfo_value;
    logic                                       o_cycle_start;

    lfo_sample_checker sb;
    t_rx_mode          rx_mode = RX_ALWAYS;
    bit                hold_req = 1'b0;

    // fixed list so that every shape code, the spare ones too, is named
    logic [2:0] shape_list [8] = '{lfo_wg_pkg::SHAPE_SINE, lfo_wg_pkg::SHAPE_TRIANGLE,
                                   lfo_wg_pkg::SHAPE_SAW, lfo_wg_pkg::SHAPE_SQUARE,
                                   lfo_wg_pkg::SHAPE_RANDOM, lfo_wg_pkg::SHAPE_SMOOTH,
                                   SHAPE_SPARE_LO, SHAPE_SPARE_HI};

    lfo_waveform_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_retrigger   (i_retrigger),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_lfo_value   (o_lfo_value),
        .o_cycle_start (o_cycle_start)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // monitor: both handshakes sampled at the rising edge, tick noted before the sample check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_tick(i_retrigger);
            if (o_out_valid && i_out_ready) sb.check_sample(o_lfo_value, o_cycle_start);
        end
    end

    // receiver: its own stall pattern, plus a long hold-off counted here on request
    initial begin
        int hold_left;
        int rx_run;
        bit rx_level;
        hold_left   = 0;
        rx_run      = 0;
        rx_level    = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        // alternating runs of ready and stall of random length
                        if (rx_run == 0) begin
                            rx_level = !rx_level;
                            rx_run   = rx_level ? $urandom_range(1, 20) : $urandom_range(1, 40);
                        end
                        rx_run--;
                        i_out_ready <= rx_level;
                    end
                endcase
            end
        end
    end

    // offer one tick from the next falling edge and hold it until taken; valid stays up
    task automatic send_tick(input bit retrig);
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_retrigger <= retrig;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // sender gap, retrigger keeps toggling underneath
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid  <= 1'b0;
            i_retrigger <= 1'($urandom_range(0, 1));
        end
    endtask

    task automatic write_reg(input logic [lfo_wg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lfo_wg_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every owed sample is out and the block has gone quiet
    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // bursts of back-to-back ticks with random gaps, retrigger one in retrig_odds+1
    task automatic run_ticks(input int count, input int retrig_odds);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > left) burst = left;
            repeat (burst) send_tick($urandom_range(0, retrig_odds) == 0);
            left -= burst;
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 25));
        end
        idle_sender(1);
    endtask

    // new random setting, each register touched with its extremes among the choices
    task automatic shuffle_regs();
        logic [lfo_wg_pkg::CFG_DATA_W-1:0] v;
        int                                pick;
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
                0:       v = 32'h7FFF_FFFF;
                1:       v = '0;
                2:       v = $urandom_range(1, 4096);
                default: v = $urandom;    // bit 31 is dropped by the block
            endcase
            write_reg(lfo_wg_pkg::REG_PHASE_INC, v);
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
                0:       v = '0;
                1:       v = 32'(lfo_wg_pkg::DEPTH_FULL);
                2:       v = 32'h0000_FFFF;          // saturates to full depth
                3:       v = $urandom_range(0, 32768);
                default: v = $urandom;
            endcase
            write_reg(lfo_wg_pkg::REG_DEPTH_TGT, v);
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
                0:       v = '0;
                1:       v = 32'h0000_FFFF;
                default: v = $urandom;
            endcase
            write_reg(lfo_wg_pkg::REG_START_PHASE, v);
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            v    = (pick < 8) ? 32'(shape_list[pick]) : 32'(lfo_wg_pkg::SHAPE_SMOOTH);
            write_reg(lfo_wg_pkg::REG_WAVE_SHAPE, v);
        end
        if ($urandom_range(0, 1)) write_reg(lfo_wg_pkg::REG_TRIG_SYNC, $urandom);
        if ($urandom_range(0, 1)) write_reg(lfo_wg_pkg::REG_BIPOLAR, $urandom);
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
                0:       v = '0;                     // taken as one
                1:       v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            write_reg(lfo_wg_pkg::REG_RANDOM_SEED, v);
        end
        if ($urandom_range(0, 7) == 0) write_reg(REG_NONE, $urandom);
    endtask

    initial begin
        int sent;
        int phase_no;
        int n;
        int waited;

        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_retrigger = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: sine at the reset rate, retrigger ignored while sync is off
        rx_mode = RX_ALWAYS;
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        idle_sender(1);
        settle();

        // fastest rate (bit 31 dropped), over-range depth, last start phase, zero seed,
        // unipolar, trigger sync on, and a write to an index with no register
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        write_reg(lfo_wg_pkg::REG_PHASE_INC, 32'hFFFF_FFFF);
        write_reg(lfo_wg_pkg::REG_DEPTH_TGT, 32'h0000_FFFF);
        write_reg(lfo_wg_pkg::REG_START_PHASE, 32'h0000_FFFF);
        write_reg(lfo_wg_pkg::REG_TRIG_SYNC, 32'd1);
        write_reg(lfo_wg_pkg::REG_BIPOLAR, 32'd0);
        write_reg(lfo_wg_pkg::REG_RANDOM_SEED, 32'd0);

        // every shape code from a retriggered phase, which wraps on the first tick
        foreach (shape_list[s]) begin
            settle();
            write_reg(lfo_wg_pkg::REG_WAVE_SHAPE, 32'(shape_list[s]));
            send_tick(1'b1);
            send_tick(1'b0);
            idle_sender(1);
        end

        // zero depth, zero rate, square
        settle();
        write_reg(lfo_wg_pkg::REG_DEPTH_TGT, 32'd0);
        write_reg(lfo_wg_pkg::REG_BIPOLAR, 32'd1);
        write_reg(lfo_wg_pkg::REG_PHASE_INC, 32'd0);
        write_reg(lfo_wg_pkg::REG_WAVE_SHAPE, 32'(lfo_wg_pkg::SHAPE_SQUARE));
        send_tick(1'b0);
        send_tick(1'b0);
        idle_sender(1);

        // triangle peak at a quarter cycle saturates to +1 minus one lsb
        settle();
        write_reg(lfo_wg_pkg::REG_DEPTH_TGT, 32'(lfo_wg_pkg::DEPTH_FULL));
        write_reg(lfo_wg_pkg::REG_START_PHASE, 32'h0000_4000);
        write_reg(lfo_wg_pkg::REG_WAVE_SHAPE, 32'(lfo_wg_pkg::SHAPE_TRIANGLE));
        send_tick(1'b1);
        send_tick(1'b1);
        idle_sender(1);

        // saw minimum in unipolar mode floors to zero
        settle();
        write_reg(lfo_wg_pkg::REG_START_PHASE, 32'd0);
        write_reg(lfo_wg_pkg::REG_BIPOLAR, 32'd0);
        write_reg(lfo_wg_pkg::REG_WAVE_SHAPE, 32'(lfo_wg_pkg::SHAPE_SAW));
        send_tick(1'b1);
        idle_sender(1);

        // random phases; the sender pauses for every owed sample between them
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_TICKS) begin
            settle();
            shuffle_regs();
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            // one phase runs into a long receiver hold-off so the block backs up
            if (phase_no == 3) hold_req = 1'b1;
            n = $urandom_range(20, 80);
            run_ticks(n, $urandom_range(1, 15));
            sent += n;
            phase_no++;
        end

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d samples never came out", sb.pending()));

        if (sb.mismatches == 0) begin
            $display("lfo_waveform_generator_unit_tb: clean");
        end else begin
            $display("lfo_waveform_generator_unit_tb: errors");
        end
        $finish;
    end

    // run limit, well past the slowest legal run
    initial begin
        #3_000_000;
        $display("lfo_waveform_generator_unit_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/lfo_wg_pkg.sv
rtl/lfo_wg_ctrl.sv
rtl/lfo_wg_dp.sv
rtl/lfo_waveform_generator_unit.sv
dv/lfo_waveform_generator_unit_tb.sv
